[hdl/dart_pkg.sv]
// ----------------------------------------------------------------------------
// dart_pkg: shared types and constants for the divider and reload timer
// Item and result structs, action and register address codes, mode thresholds.
// ----------------------------------------------------------------------------
package dart_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	localparam logic [15:0] ADDR_DIV  = 16'hFF04;
	localparam logic [15:0] ADDR_TIMA = 16'hFF05;
	localparam logic [15:0] ADDR_TMA  = 16'hFF06;
	localparam logic [15:0] ADDR_TAC  = 16'hFF07;

	localparam logic [1:0] MODE_64 = 2'd0;
	localparam logic [1:0] MODE_1  = 2'd1;
	localparam logic [1:0] MODE_4  = 2'd2;
	localparam logic [1:0] MODE_16 = 2'd3;

	localparam logic [7:0] ACC_STEP  = 8'd4;
	localparam logic [7:0] ACC_LIMIT = 8'd3;
	localparam logic [7:0] CNT_MAX   = 8'd255;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  cycles;
		logic [15:0] address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} result_t;

	function automatic logic [7:0] mode_threshold(input logic [1:0] mode);
		logic [7:0] thr;
		unique case (mode)
			MODE_64: thr = 8'd64;
			MODE_1:  thr = 8'd1;
			MODE_4:  thr = 8'd4;
			MODE_16: thr = 8'd16;
			default: thr = 8'd64;
		endcase
		return thr;
	endfunction

endpackage

[hdl/dart_in_stage.sv]
// ----------------------------------------------------------------------------
// dart_in_stage: input register
// Captures one item per cycle and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module dart_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [3:0]           cycles,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	input  logic                 advance,
	output logic                 item_valid_s1,
	output dart_pkg::item_t      item_s1
);
	import dart_pkg::*;

	assign in_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action     <= action;
			item_s1.cycles     <= cycles;
			item_s1.address    <= address;
			item_s1.write_data <= write_data;
		end
	end

endmodule

[hdl/dart_core.sv]
// ----------------------------------------------------------------------------
// dart_core: timer state and single-pass update
// Holds accumulator, base count, divider, counter, reload and control;
// applies one tick, read or write per advance and forms its result.
// ----------------------------------------------------------------------------
module dart_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  dart_pkg::item_t      item_s1,
	output dart_pkg::result_t    result
);
	import dart_pkg::*;

	logic [7:0] cycle_accum_q;
	logic [7:0] base_count_q;
	logic [3:0] div_prescale_q;
	logic [7:0] divider_q;
	logic [7:0] counter_q;
	logic [7:0] reload_q;
	logic [2:0] control_q;

	logic [7:0] acc_sum;
	logic       acc_step;
	logic [7:0] acc_next;
	logic [7:0] base_inc;
	logic [3:0] pre_next;
	logic       hit;
	logic       ovf;
	logic       is_tick;
	logic       is_write;
	logic [7:0] rd_mux;

	assign is_tick  = (item_s1.action == ACT_TICK);
	assign is_write = (item_s1.action == ACT_WRITE);

	assign acc_sum  = cycle_accum_q + {4'd0, item_s1.cycles};
	assign acc_step = (acc_sum > ACC_LIMIT);
	assign acc_next = acc_step ? (acc_sum - ACC_STEP) : acc_sum;
	assign base_inc = base_count_q + {7'd0, acc_step};
	assign pre_next = div_prescale_q + {3'd0, acc_step};
	assign hit      = control_q[2] && (base_inc >= mode_threshold(control_q[1:0]));
	assign ovf      = hit && (counter_q == CNT_MAX);

	always_comb begin
		unique case (item_s1.address)
			ADDR_DIV:  rd_mux = divider_q;
			ADDR_TIMA: rd_mux = counter_q;
			ADDR_TMA:  rd_mux = reload_q;
			ADDR_TAC:  rd_mux = {5'd0, control_q};
			default:   rd_mux = 8'd0;
		endcase
	end

	assign result.read_data = (item_s1.action == ACT_READ) ? rd_mux : 8'd0;
	assign result.timer_irq = is_tick && ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_accum_q  <= '0;
			base_count_q   <= '0;
			div_prescale_q <= '0;
			divider_q      <= '0;
			counter_q      <= '0;
			reload_q       <= '0;
			control_q      <= '0;
		end else if (advance && is_tick) begin
			cycle_accum_q  <= acc_next;
			div_prescale_q <= pre_next;
			if (acc_step && pre_next == 4'd0) begin
				divider_q <= divider_q + 8'd1;
			end
			if (hit) begin
				base_count_q <= 8'd0;
				counter_q    <= ovf ? reload_q : counter_q + 8'd1;
			end else begin
				base_count_q <= base_inc;
			end
		end else if (advance && is_write) begin
			unique case (item_s1.address)
				ADDR_DIV:  divider_q <= 8'd0;
				ADDR_TIMA: counter_q <= item_s1.write_data;
				ADDR_TMA:  reload_q  <= item_s1.write_data;
				ADDR_TAC:  control_q <= item_s1.write_data[2:0];
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(counter_q) && $stable(divider_q) && $stable(cycle_accum_q))
		else $error("timer state changed without an item");
	a_ovf_reload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.timer_irq |=> counter_q == $past(reload_q))
		else $error("counter did not reload on overflow");
	a_read_no_touch: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_tick && !is_write |=> $stable(counter_q) && $stable(base_count_q))
		else $error("read item changed timer state");
	a_hit_clears_base: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_tick && hit |=> base_count_q == 8'd0)
		else $error("base count not cleared on counter step");
`endif

endmodule

[hdl/divider_and_reload_timer_unit.sv]
// ----------------------------------------------------------------------------
// divider_and_reload_timer_unit: divider / counter / reload / control timer
// Result path: the input stage registers each accepted item, and the result register captures its result on advance.
// Throughput: 1 item per cycle while the output is not stalled; state updates in a single pass per item.
// Reset: arst_n clears all timer registers and both valid flags asynchronously.
// One result per item; while the result register waits, the input stage can still take one item.
// ----------------------------------------------------------------------------
module divider_and_reload_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  cycles,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        timer_irq
);
	import dart_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	result_t result;
	logic    advance;
	logic    out_valid_q;
	result_t result_q;

	assign advance = item_valid_s1 && (!out_valid_q || !out_stall);

	dart_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.cycles        (cycles),
		.address       (address),
		.write_data    (write_data),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	dart_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = result_q.read_data;
	assign timer_irq = result_q.timer_irq;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(result_q))
		else $error("stalled result changed");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && out_valid_q && out_stall |-> in_stall)
		else $error("input taken while both stages full");
	a_irq_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && timer_irq |-> read_data == 8'd0)
		else $error("irq result carries read data");
`endif

endmodule

[verif/divider_and_reload_timer_unit_test.sv]
// ----------------------------------------------------------------------------
// divider_and_reload_timer_unit_test: item-level check of the timer unit
// Drives ticks, register reads and writes, and idle actions through the valid /
// stall handshake with random gaps on both sides, tracks the timer registers
// in a shadow copy, and compares every result with the one the shadow expects.
// ----------------------------------------------------------------------------
module divider_and_reload_timer_unit_test;
	import dart_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;

	class timer_shadow;
		logic [7:0] accum;
		logic [7:0] base;
		logic [3:0] prescale;
		logic [7:0] div_reg;
		logic [7:0] tima;
		logic [7:0] tma;
		logic [2:0] tac;
		result_t    expected_results[$];
		int         mismatch_count;

		function new();
			accum = '0;
			base = '0;
			prescale = '0;
			div_reg = '0;
			tima = '0;
			tma = '0;
			tac = '0;
			mismatch_count = 0;
		endfunction

		task report_mismatch(input string what);
			mismatch_count++;
			if (mismatch_count <= 100)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		function int pending();
			return expected_results.size();
		endfunction

		function void note_item(input logic [1:0] act, input logic [3:0] cyc,
				input logic [15:0] addr, input logic [7:0] data);
			result_t    res;
			logic [7:0] thr;
			res = '0;
			case (act)
				ACT_TICK: begin
					accum = accum + {4'd0, cyc};
					if (accum > ACC_LIMIT) begin
						accum = accum - ACC_STEP;
						base = base + 8'd1;
						prescale = prescale + 4'd1;
						if (prescale == 4'd0)
							div_reg = div_reg + 8'd1;
					end
					case (tac[1:0])
						MODE_64: thr = 8'd64;
						MODE_1:  thr = 8'd1;
						MODE_4:  thr = 8'd4;
						default: thr = 8'd16;
					endcase
					if (tac[2] && base >= thr) begin
						base = '0;
						if (tima == CNT_MAX) begin
							tima = tma;
							res.timer_irq = 1'b1;
						end else begin
							tima = tima + 8'd1;
						end
					end
				end
				ACT_READ: begin
					case (addr)
						ADDR_DIV:  res.read_data = div_reg;
						ADDR_TIMA: res.read_data = tima;
						ADDR_TMA:  res.read_data = tma;
						ADDR_TAC:  res.read_data = {5'd0, tac};
						default:   res.read_data = '0;
					endcase
				end
				ACT_WRITE: begin
					case (addr)
						ADDR_DIV:  div_reg = '0;
						ADDR_TIMA: tima = data;
						ADDR_TMA:  tma = data;
						ADDR_TAC:  tac = data[2:0];
						default: ;
					endcase
				end
				default: ;
			endcase
			expected_results.push_back(res);
		endfunction

		task check_result(input logic [7:0] rd, input logic irq);
			result_t exp_res;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result rd=%02h irq=%b with nothing pending",
					rd, irq));
			end else begin
				exp_res = expected_results.pop_front();
				if (rd !== exp_res.read_data)
					report_mismatch($sformatf("read_data %02h, expected %02h",
						rd, exp_res.read_data));
				if (irq !== exp_res.timer_irq)
					report_mismatch($sformatf("timer_irq %b, expected %b",
						irq, exp_res.timer_irq));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [3:0]  cycles = '0;
	logic [15:0] address = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        timer_irq;

	timer_shadow shadow = new();
	int          items_accepted = 0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	bit          hold_long = 1'b0;
	int          rx_hold_left = 0;

	divider_and_reload_timer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.cycles     (cycles),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.timer_irq  (timer_irq)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				shadow.note_item(action, cycles, address, write_data);
				items_accepted++;
			end
			if (out_valid && !out_stall)
				shadow.check_result(read_data, timer_irq);
		end
	end

	always @(negedge clk) begin
		if (rx_hold_left > 0)
			rx_hold_left--;
		else if (rx_idle && $urandom_range(0, 5) == 0)
			rx_hold_left = $urandom_range(1, 10);
		out_stall <= hold_long || (rx_hold_left > 0);
	end

	initial begin
		wait (items_accepted >= 400);
		@(posedge clk);
		hold_long = 1'b1;
		repeat (60) @(posedge clk);
		hold_long = 1'b0;
	end

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(input logic [1:0] act, input logic [3:0] cyc,
			input logic [15:0] addr, input logic [7:0] data);
		int gap;
		gap = (tx_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		cycles <= cyc;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_tick_run(input int n);
		repeat (n)
			send_item(ACT_TICK, 4'hF, 16'($urandom), 8'($urandom));
	endtask

	task automatic send_random_item();
		int          pick;
		logic [3:0]  cyc;
		logic [15:0] addr;
		logic [7:0]  data;
		pick = $urandom_range(0, 99);
		cyc = 4'($urandom);
		addr = 16'($urandom);
		data = 8'($urandom);
		if (pick < 55) begin
			if ($urandom_range(0, 3) == 0)
				cyc = 4'hF;
			send_item(ACT_TICK, cyc, addr, data);
		end else if (pick < 70) begin
			send_item(ACT_READ, cyc, ADDR_DIV + 16'($urandom_range(0, 3)), data);
		end else if (pick < 85) begin
			addr = ADDR_DIV + 16'($urandom_range(0, 3));
			if (addr == ADDR_TIMA && $urandom_range(0, 1) == 0)
				data = 8'($urandom_range(240, 255));
			send_item(ACT_WRITE, cyc, addr, data);
		end else if (pick < 93) begin
			if ($urandom_range(0, 1) == 0)
				addr = $urandom_range(0, 1) ? 16'hFF03 : 16'hFF08;
			send_item($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, cyc, addr, data);
		end else begin
			send_item(ACT_NONE, cyc, addr, data);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(ACT_READ, 4'h0, ADDR_DIV, 8'h00);
		send_item(ACT_READ, 4'hF, ADDR_TIMA, 8'hFF);
		send_item(ACT_READ, 4'h0, ADDR_TMA, 8'h00);
		send_item(ACT_READ, 4'h0, ADDR_TAC, 8'h00);
		send_item(ACT_WRITE, 4'h0, ADDR_TMA, 8'hAB);
		send_item(ACT_WRITE, 4'h0, ADDR_TIMA, 8'hFF);
		send_item(ACT_WRITE, 4'hF, ADDR_TAC, 8'hFD);
		send_item(ACT_READ, 4'h0, ADDR_TAC, 8'h00);
		send_item(ACT_TICK, 4'hF, 16'hFFFF, 8'hFF);
		send_item(ACT_TICK, 4'h0, 16'h0000, 8'h00);
		send_item(ACT_READ, 4'h0, ADDR_TIMA, 8'h00);
		send_item(ACT_NONE, 4'hF, ADDR_TIMA, 8'hFF);
		send_item(ACT_WRITE, 4'h0, ADDR_DIV, 8'h5A);
		send_item(ACT_READ, 4'h0, ADDR_DIV, 8'h00);
		send_item(ACT_WRITE, 4'h0, 16'hFF08, 8'h77);
		send_item(ACT_READ, 4'h0, 16'hFF03, 8'h00);
		send_item(ACT_READ, 4'h0, 16'h0000, 8'h00);
		send_item(ACT_WRITE, 4'h0, ADDR_TAC, 8'h04);
		send_item(ACT_TICK, 4'h4, 16'h0000, 8'h00);
		send_item(ACT_WRITE, 4'h0, ADDR_TAC, 8'h06);
		send_item(ACT_TICK, 4'h8, 16'h0000, 8'h00);
		send_item(ACT_WRITE, 4'h0, ADDR_TAC, 8'h03);
		send_item(ACT_WRITE, 4'h0, ADDR_TIMA, 8'h00);
		send_item(ACT_WRITE, 4'h0, ADDR_TMA, 8'hFF);
		send_item(ACT_TICK, 4'hF, 16'h0000, 8'h00);

		for (int chunk = 0; chunk < 12; chunk++) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1) == 0)
				send_tick_run(30);
			repeat (100) send_random_item();
		end

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (150) send_random_item();
		@(negedge clk);
		in_valid <= 1'b0;

		while (shadow.pending() != 0 || hold_long) @(posedge clk);
		repeat (8) @(posedge clk);
		if (shadow.mismatch_count == 0 && shadow.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[divider_and_reload_timer_unit.f]
hdl/dart_pkg.sv
hdl/dart_in_stage.sv
hdl/dart_core.sv
hdl/divider_and_reload_timer_unit.sv
verif/divider_and_reload_timer_unit_test.sv
